// File: rtl/mmr_pkg.sv
`timescale 1ns / 1ps
package mmr_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int VALUE_BITS = 32;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 11;
	localparam int IDX_W      = $clog2(MAX_LEN);
	localparam int LEN_W      = $clog2(MAX_LEN + 1);
	localparam int ADDR_W     = IDX_W + 1;

	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] n;
		logic             ovf;
	} job_t;

	typedef struct packed {
		logic                  en;
		logic [ADDR_W-1:0]     addr;
		logic [VALUE_BITS-1:0] data;
	} vwr_t;

endpackage

// File: rtl/mmr_in_if.sv
`timescale 1ns / 1ps
interface mmr_in_if;
	import mmr_pkg::*;

	logic            valid;
	logic            ready;
	logic [IN_W-1:0] value;
	logic            last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);

endinterface

// File: rtl/mmr_out_if.sv
`timescale 1ns / 1ps
interface mmr_out_if;
	import mmr_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] removals;
	logic             overflow;

	modport source (output valid, output removals, output overflow, input ready);
	modport sink (input valid, input removals, input overflow, output ready);

endinterface

// File: rtl/min_mountain_removals.sv
`timescale 1ns / 1ps
// channel | dir | payload                          | handshake
// item    | in  | value[31:0], last                | valid / ready
// result  | out | removals[10:0], overflow         | valid / ready
//
// Items load at one per cycle, while item.ready is high, into one of two value banks.
// After the last item of n, the back end builds its rise and fall tables: each
// table row sweeps the earlier (or later) entries one per cycle through a
// single read port on the value and length memories.
// item.ready drops only while two finished sequences still wait on the back end.
// Reset clears counters and control; the memories are never cleared.
module min_mountain_removals (
	input  logic      clk,
	input  logic      arst_n,
	mmr_in_if.sink    item,
	mmr_out_if.source result
);
	import mmr_pkg::*;

	vwr_t vwr;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic empty;
	job_t head;
	logic release_job;

	mmr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.vwr         (vwr),
		.push        (push),
		.push_job    (push_job),
		.release_job (release_job)
	);

	mmr_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	mmr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.vwr         (vwr),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.release_job (release_job),
		.result      (result)
	);

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into a full queue");

endmodule

// File: rtl/mmr_job_fifo.sv
`timescale 1ns / 1ps
module mmr_job_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mmr_pkg::job_t push_job,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output mmr_pkg::job_t head
);
	import mmr_pkg::*;

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       pop_ok;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign head    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok) begin
				wp_q <= !wp_q;
			end
			if (pop_ok) begin
				rp_q <= !rp_q;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/mmr_front.sv
`timescale 1ns / 1ps
module mmr_front (
	input  logic          clk,
	input  logic          arst_n,
	mmr_in_if.sink        item,
	output mmr_pkg::vwr_t vwr,
	output logic          push,
	output mmr_pkg::job_t push_job,
	input  logic          release_job
);
	import mmr_pkg::*;

	logic [LEN_W-1:0] cnt_q;
	logic             drop_q;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic             acc;
	logic             keep;
	logic [LEN_W-1:0] n_next;

	// hold off while both value banks belong to unfinished sequences
	assign item.ready = (busy_q != 2'd2);
	assign acc        = item.valid && item.ready;
	assign keep       = (cnt_q < LEN_W'(MAX_LEN));
	assign n_next     = keep ? LEN_W'(cnt_q + 1'b1) : cnt_q;

	assign vwr.en   = acc && keep;
	assign vwr.addr = {bank_q, cnt_q[IDX_W-1:0]};
	assign vwr.data = VALUE_BITS'(item.value);

	assign push          = acc && item.last;
	assign push_job.bank = bank_q;
	assign push_job.n    = n_next;
	assign push_job.ovf  = drop_q || !keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= 2'd0;
		end else begin
			if (acc) begin
				if (item.last) begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
					bank_q <= !bank_q;
				end else begin
					cnt_q  <= n_next;
					drop_q <= drop_q || !keep;
				end
			end
			case ({push, release_job})
				2'b10:   busy_q <= busy_q + 2'd1;
				2'b01:   busy_q <= busy_q - 2'd1;
				default: busy_q <= busy_q;
			endcase
		end
	end

endmodule

// File: rtl/mmr_back.sv
`timescale 1ns / 1ps
module mmr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mmr_pkg::vwr_t vwr,
	input  logic          empty,
	input  mmr_pkg::job_t head,
	output logic          pop,
	output logic          release_job,
	mmr_out_if.source     result
);
	import mmr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ROW  = 5'b00010,
		S_LOAD = 5'b00100,
		S_SCAN = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	logic [VALUE_BITS-1:0] vmem [2*MAX_LEN];
	logic [LEN_W-1:0]      rmem [MAX_LEN];
	logic [LEN_W-1:0]      fmem [MAX_LEN];

	state_t                state_q;
	logic                  fall_q;
	logic                  bank_q;
	logic [LEN_W-1:0]      n_q;
	logic                  ovf_q;
	logic [LEN_W-1:0]      i_q;
	logic [LEN_W-1:0]      j_q;
	logic [VALUE_BITS-1:0] vi_q;
	logic [LEN_W-1:0]      ri_q;
	logic [LEN_W-1:0]      longest_q;
	logic [LEN_W:0]        best_q;
	logic                  rv_s1;

	logic [VALUE_BITS-1:0] vrd_q;
	logic [LEN_W-1:0]      rrd_q;
	logic [LEN_W-1:0]      frd_q;

	logic [ADDR_W-1:0]     vaddr;
	logic [IDX_W-1:0]      raddr;
	logic [LEN_W-1:0]      lim;
	logic                  issue;
	logic [LEN_W-1:0]      len_rd;
	logic                  hit;
	logic                  row_end;
	logic [LEN_W-1:0]      new_len;
	logic [LEN_W:0]        cand;
	logic                  peak;

	assign vaddr   = (state_q == S_ROW) ? {bank_q, i_q[IDX_W-1:0]}
	                                    : {bank_q, j_q[IDX_W-1:0]};
	assign raddr   = fall_q ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
	assign lim     = fall_q ? n_q : i_q;
	assign issue   = (state_q == S_SCAN) && (j_q < lim);
	assign len_rd  = fall_q ? frd_q : rrd_q;
	assign hit     = rv_s1 && (vrd_q < vi_q) && (len_rd > longest_q);
	assign row_end = (state_q == S_SCAN) && !issue && !rv_s1;
	assign new_len = LEN_W'(longest_q + 1'b1);
	assign cand    = (LEN_W + 1)'({1'b0, ri_q} + {1'b0, new_len} - 1'b1);
	assign peak    = (ri_q > LEN_W'(1)) && (new_len > LEN_W'(1));

	assign pop             = (state_q == S_IDLE) && !empty;
	assign result.valid    = (state_q == S_OUT);
	assign result.removals = OUT_W'({1'b0, n_q} - best_q);
	assign result.overflow = ovf_q;
	assign release_job     = (state_q == S_OUT) && result.ready;

	always_ff @(posedge clk) begin
		if (vwr.en) begin
			vmem[vwr.addr] <= vwr.data;
		end
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (row_end && !fall_q) begin
			rmem[i_q[IDX_W-1:0]] <= new_len;
		end
		rrd_q <= rmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (row_end && fall_q) begin
			fmem[i_q[IDX_W-1:0]] <= new_len;
		end
		frd_q <= fmem[j_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fall_q    <= 1'b0;
			bank_q    <= 1'b0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			vi_q      <= '0;
			ri_q      <= '0;
			longest_q <= '0;
			best_q    <= '0;
			rv_s1     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						bank_q  <= head.bank;
						n_q     <= head.n;
						ovf_q   <= head.ovf;
						fall_q  <= 1'b0;
						i_q     <= '0;
						best_q  <= '0;
						state_q <= (head.n == '0) ? S_OUT : S_ROW;
					end
				end
				S_ROW: begin
					j_q       <= fall_q ? LEN_W'(i_q + 1'b1) : '0;
					longest_q <= '0;
					rv_s1     <= 1'b0;
					state_q   <= S_LOAD;
				end
				S_LOAD: begin
					vi_q    <= vrd_q;
					ri_q    <= rrd_q;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					rv_s1 <= issue;
					if (issue) begin
						j_q <= LEN_W'(j_q + 1'b1);
					end
					if (hit) begin
						longest_q <= len_rd;
					end
					if (row_end) begin
						if (!fall_q) begin
							// advance to the next rise row, or turn around
							if (LEN_W'(i_q + 1'b1) == n_q) begin
								fall_q <= 1'b1;
								i_q    <= LEN_W'(n_q - 1'b1);
							end else begin
								i_q <= LEN_W'(i_q + 1'b1);
							end
							state_q <= S_ROW;
						end else begin
							if (peak && (cand > best_q)) begin
								best_q <= cand;
							end
							if (i_q == '0) begin
								state_q <= S_OUT;
							end else begin
								i_q     <= LEN_W'(i_q - 1'b1);
								state_q <= S_ROW;
							end
						end
					end
				end
				S_OUT: begin
					if (result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (best_q <= {1'b0, n_q}))
		else $error("mountain length exceeds sequence length");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_end |-> (i_q < n_q))
		else $error("row index beyond stored length");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (j_q <= lim))
		else $error("scan index ran past its limit");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != S_IDLE))
		else $error("request taken from queue but back end stayed idle");

endmodule

// File: bench/tb_min_mountain_removals.sv
`timescale 1ns / 1ps
module tb_min_mountain_removals;
	import mmr_pkg::*;

	localparam int HOLD_CYCLES = 3000;
	localparam int QUIET_LIMIT = 4_000_000;
	localparam int RANDOM_REQS = 580;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [OUT_W-1:0] removals;
		logic             overflow;
	} outcome_t;

	typedef struct packed {
		logic [IN_W-1:0]  value;
		logic             last;
		bit               typed;
		logic [OUT_W-1:0] removals;
		logic             overflow;
	} step_t;

	typedef enum int {SHAPE_PEAK, SHAPE_FEW, SHAPE_ANY, SHAPE_VALLEY} shape_t;

	localparam step_t DIRECTED [24] = '{
		'{32'h0000_002A, 1'b1, 1'b1, 11'd1, 1'b0},
		'{32'd5,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd9,         1'b1, 1'b1, 11'd2, 1'b0},
		'{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd3,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd2,         1'b1, 1'b1, 11'd0, 1'b0},
		'{32'd7,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd7,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd7,         1'b1, 1'b1, 11'd3, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0000, 1'b1, 1'b1, 11'd0, 1'b0},
		'{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd2,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd3,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd4,         1'b1, 1'b1, 11'd4, 1'b0},
		'{32'd2,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd5,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd6,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd2,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd3,         1'b0, 1'b0, 11'd0, 1'b0},
		'{32'd1,         1'b1, 1'b0, 11'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	mmr_in_if  item ();
	mmr_out_if result ();

	min_mountain_removals DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	logic [VALUE_BITS-1:0] held_vals[$];
	logic                  held_dropped = 1'b0;
	outcome_t              removals_due[$];

	int  mismatches = 0;
	int  reqs_sent = 0;
	int  seqs_sent = 0;
	int  seq_len = 0;
	int  longest_seq = 0;
	int  results_seen = 0;
	int  overflow_seen = 0;
	int  quiet_cycles = 0;
	int  burst_left = 0;
	bit  wind_down = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [OUT_W-1:0] mountain_removals();
		int rise [MAX_LEN];
		int fall [MAX_LEN];
		int n;
		int best;
		int longest;
		n = held_vals.size();
		best = 0;
		for (int i = 0; i < n; i++) begin
			longest = 0;
			for (int j = 0; j < i; j++)
				if (held_vals[j] < held_vals[i] && rise[j] > longest)
					longest = rise[j];
			rise[i] = longest + 1;
		end
		for (int i = n - 1; i >= 0; i--) begin
			longest = 0;
			for (int j = i + 1; j < n; j++)
				if (held_vals[i] > held_vals[j] && fall[j] > longest)
					longest = fall[j];
			fall[i] = longest + 1;
		end
		for (int i = 0; i < n; i++)
			if (rise[i] > 1 && fall[i] > 1 && rise[i] + fall[i] - 1 > best)
				best = rise[i] + fall[i] - 1;
		return OUT_W'(n - best);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic offer(input logic [IN_W-1:0] v, input logic l, input bit typed,
			input logic [OUT_W-1:0] rem, input logic ovf);
		item.valid <= 1'b1;
		item.value <= v;
		item.last  <= l;
		do @(posedge clk); while (!(item.valid && item.ready));
		reqs_sent++;
		seq_len++;
		if (held_vals.size() < MAX_LEN)
			held_vals.push_back(v[VALUE_BITS-1:0]);
		else
			held_dropped = 1'b1;
		if (l) begin
			if (typed)
				removals_due.push_back({rem, ovf});
			else
				removals_due.push_back({mountain_removals(), held_dropped});
			held_vals.delete();
			held_dropped = 1'b0;
			seqs_sent++;
			if (seq_len > longest_seq)
				longest_seq = seq_len;
			seq_len = 0;
		end
		if (wind_down) begin
			item.valid <= 1'b0;
		end else if (burst_left == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_random_sequence();
		int              len;
		int              peak;
		int              pick;
		shape_t          shape;
		logic [IN_W-1:0] lvl;
		logic [IN_W-1:0] v;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
		pick = $urandom_range(0, 9);
		shape = (pick < 5) ? SHAPE_PEAK : (pick < 7) ? SHAPE_FEW :
		        (pick < 9) ? SHAPE_ANY : SHAPE_VALLEY;
		peak = $urandom_range(0, len - 1);
		lvl = $urandom >> $urandom_range(0, 31);
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_PEAK: begin
					if ($urandom_range(0, 7) == 0) begin
						v = $urandom;
					end else begin
						lvl = (i <= peak) ? lvl + $urandom_range(0, 4) : lvl - $urandom_range(0, 4);
						v = lvl;
					end
				end
				SHAPE_FEW: v = $urandom_range(0, 5);
				SHAPE_ANY: v = $urandom;
				SHAPE_VALLEY: begin
					lvl = (i <= peak) ? lvl - $urandom_range(0, 4) : lvl + $urandom_range(0, 4);
					v = lvl;
				end
				default: v = $urandom;
			endcase
			offer(v, i == len - 1, 1'b0, '0, 1'b0);
		end
	endtask

	// receiver: random ready patterns, one long hold once traffic is flowing
	initial begin
		int  mode;
		int  span;
		int  tick;
		bit  held;
		mode = 0;
		span = 0;
		tick = 0;
		held = 1'b0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (!held && results_seen >= 25) begin
				held = 1'b1;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 2);
					span = $urandom_range(20, 300);
				end
				span--;
				case (mode)
					0: result.ready <= 1'b1;
					1: result.ready <= ($urandom_range(0, 9) < 6);
					default: result.ready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (result.valid && result.ready) begin
			results_seen++;
			if (removals_due.size() == 0) begin
				flag_mismatch($sformatf("result with nothing due: removals=%0d overflow=%0b",
					result.removals, result.overflow));
			end else begin
				want = removals_due.pop_front();
				if (result.removals !== want.removals)
					flag_mismatch($sformatf("removals got %0d want %0d",
						result.removals, want.removals));
				if (result.overflow !== want.overflow)
					flag_mismatch($sformatf("overflow got %0b want %0b",
						result.overflow, want.overflow));
				if (want.overflow)
					overflow_seen++;
			end
		end
		if ((item.valid && item.ready) || (result.valid && result.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int              random_sent;
		logic [IN_W-1:0] v;
		arst_n     <= 1'b0;
		item.valid <= 1'b0;
		item.value <= '0;
		item.last  <= 1'b0;
		burst_left = $urandom_range(1, 12);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k])
			offer(DIRECTED[k].value, DIRECTED[k].last, DIRECTED[k].typed,
				DIRECTED[k].removals, DIRECTED[k].overflow);

		random_sent = reqs_sent;
		while (reqs_sent - random_sent < RANDOM_REQS)
			send_random_sequence();

		// overfill one sequence: strictly rising, then dropped requests, last one dropped
		for (int i = 0; i < MAX_LEN + 2; i++) begin
			if (i < MAX_LEN)
				v = {IDX_W'(i), (IN_W - IDX_W)'($urandom)};
			else
				v = $urandom;
			if (i == MAX_LEN + 1)
				wind_down = 1'b1;
			offer(v, i == MAX_LEN + 1, 1'b1, OUT_W'(MAX_LEN), 1'b1);
		end

		while (removals_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests in %0d sequences (longest %0d), %0d results checked",
			reqs_sent, seqs_sent, longest_seq, results_seen);
		$display("%0d results with dropped requests, one receiver hold of %0d cycles",
			overflow_seen, HOLD_CYCLES);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/mmr_pkg.sv
rtl/mmr_in_if.sv
rtl/mmr_out_if.sv
rtl/mmr_job_fifo.sv
rtl/mmr_front.sv
rtl/mmr_back.sv
rtl/min_mountain_removals.sv
bench/tb_min_mountain_removals.sv
